/* sv/swf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swf_pkg
// Shared constants, types and hash functions of the sampled window
// fingerprinter.
// ----------------------------------------------------------------------------
package swf_pkg;

  localparam int WINDOW_BYTES_DEF  = 32;
  localparam int POSITION_BITS_DEF = 24;
  localparam int HASH_SLOTS_DEF    = 32;

  localparam int MARKER_W  = 24;
  localparam int HASH_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int SKIP_W    = 8;
  localparam int MAP_W     = 64;
  localparam int MAP_WORDS = 4;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = MARKER_W + HASH_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_MAP_0 = 3'd0,
    CFG_SAMPLE_MAP_1 = 3'd1,
    CFG_SAMPLE_MAP_2 = 3'd2,
    CFG_SAMPLE_MAP_3 = 3'd3,
    CFG_SKIP_COUNT   = 3'd4
  } cfg_idx_t;

  // Per-slot control from the top level
  typedef struct packed {
    logic absorb;  // a byte is accepted this cycle
    logic start;   // open a new window in this slot
    logic last;    // the byte ends the stream
  } slot_ctl_t;

  // Per-slot status to the top level
  typedef struct packed {
    logic busy;    // window open
    logic done;    // window completes with this byte
  } slot_stat_t;

  // One one-at-a-time round
  function automatic logic [HASH_W-1:0] hash_round(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] t;
    t = h + HASH_W'(b);
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  // Final avalanche
  function automatic logic [HASH_W-1:0] hash_finish(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

/* sv/swf_slot.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swf_slot
// One hash slot: holds an open window's start position, byte count and
// partial hash, and absorbs one byte per accepted word.
// ----------------------------------------------------------------------------
module swf_slot
  import swf_pkg::*;
#(
  parameter int WINDOW_BYTES  = WINDOW_BYTES_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  slot_ctl_t                ctl,
  input  logic [BYTE_W-1:0]        data_byte,
  input  logic [POSITION_BITS-1:0] position,
  output slot_stat_t               stat,
  output logic [HASH_W-1:0]        round_hash,
  output logic [POSITION_BITS-1:0] start_pos
);

  localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WINDOW_BYTES - 1);

  logic                     busy_r, busy_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [HASH_W-1:0]        hash_r, hash_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;

  logic                     live;
  logic [CNT_W-1:0]         cnt_base;
  logic [HASH_W-1:0]        hash_base;

  always_comb begin
    live       = busy_r | ctl.start;
    cnt_base   = ctl.start ? '0 : cnt_r;
    hash_base  = ctl.start ? '0 : hash_r;
    round_hash = hash_round(hash_base, data_byte);
    start_pos  = ctl.start ? position : start_r;

    stat.busy = busy_r;
    stat.done = ctl.absorb & live & (cnt_base == LAST_CNT);

    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    hash_nxt  = hash_r;
    start_nxt = start_r;
    if (ctl.absorb) begin
      busy_nxt  = live & ~stat.done & ~ctl.last;
      cnt_nxt   = cnt_base + CNT_W'(1);
      hash_nxt  = round_hash;
      start_nxt = start_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r  <= hash_nxt;
    start_r <= start_nxt;
  end

endmodule

/* sv/sampled_window_fingerprinter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampled_window_fingerprinter_top
// Content fingerprints of a byte stream: sampled windows hashed with the
// one-at-a-time hash, one result word per window that closes before tlast.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle on the in_ side while in_tready
// is high (tlast marks the final byte of a stream). A byte whose value is
// flagged in the 256-bit sample map opens a window at its stream position,
// unless it falls in the skip run that follows the previous sample;
// skip_count sets that run. Each open window lives in its own hash slot,
// which absorbs one byte per cycle while bytes are accepted; after
// WINDOW_BYTES bytes the window closes and one word carrying the start
// position (marker) and the finished hash leaves on the out_ side. A window
// closed by the final stream byte is not reported, and the end of a stream
// drops open windows and restarts position counting at zero. Throughput is
// one byte per cycle while in_tready is high, set by the slot array doing one
// hash round per cycle; a result passes a register for the selected round
// hash, then the output register for the finishing rounds. Bytes that close
// no window are taken even while the output is stalled, if the pending-result
// register is free. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module sampled_window_fingerprinter_top
  import swf_pkg::*;
#(
  parameter int WINDOW_BYTES  = WINDOW_BYTES_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int HASH_SLOTS    = HASH_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAP_W-1:0]     cfg_wdata,
  // byte stream in
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BYTE_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                 in_tlast,   // last_byte
  // fingerprint results out
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata   // [23:0] marker, [55:24] fingerprint
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [MAP_WORDS*MAP_W-1:0] map_r;
  logic [SKIP_W-1:0]          skip_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r        <= '0;
      skip_count_r <= SKIP_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_MAP_0: map_r[0*MAP_W +: MAP_W] <= cfg_wdata;
        CFG_SAMPLE_MAP_1: map_r[1*MAP_W +: MAP_W] <= cfg_wdata;
        CFG_SAMPLE_MAP_2: map_r[2*MAP_W +: MAP_W] <= cfg_wdata;
        CFG_SAMPLE_MAP_3: map_r[3*MAP_W +: MAP_W] <= cfg_wdata;
        CFG_SKIP_COUNT:   skip_count_r <= cfg_wdata[SKIP_W-1:0];
        default: ;  // unused indexes: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: pending-result register (s1) and output register
  // --------------------------------------------------------------------------
  logic out_ready, s1_ready, in_acc;
  logic s1_v_r;

  assign out_ready = ~out_tvalid | out_tready;
  assign s1_ready  = ~s1_v_r | out_ready;
  assign in_tready = s1_ready;
  assign in_acc    = in_tvalid & in_tready;

  // --------------------------------------------------------------------------
  // Sampling decision and stream position
  // --------------------------------------------------------------------------
  logic [POSITION_BITS-1:0] position_r, position_nxt;
  logic [SKIP_W-1:0]        skip_left_r, skip_left_nxt;
  logic                     skipping, sample_hit;

  assign skipping   = (skip_left_r != '0);
  assign sample_hit = ~skipping & map_r[in_tdata];

  always_comb begin
    position_nxt  = position_r;
    skip_left_nxt = skip_left_r;
    if (in_acc) begin
      if (skipping) begin
        skip_left_nxt = skip_left_r - SKIP_W'(1);
      end else if (sample_hit) begin
        skip_left_nxt = skip_count_r;
      end
      position_nxt = position_r + POSITION_BITS'(1);
      // End of stream: start over
      if (in_tlast) begin
        position_nxt  = '0;
        skip_left_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r  <= '0;
      skip_left_r <= '0;
    end else begin
      position_r  <= position_nxt;
      skip_left_r <= skip_left_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Slot array
  // --------------------------------------------------------------------------
  slot_stat_t               stat   [HASH_SLOTS];
  logic [HASH_W-1:0]        r_hash [HASH_SLOTS];
  logic [POSITION_BITS-1:0] s_pos  [HASH_SLOTS];

  logic [HASH_SLOTS-1:0] free_vec, alloc_vec, done_vec, sel_vec;

  always_comb begin
    for (int k = 0; k < HASH_SLOTS; k++) begin
      free_vec[k] = ~stat[k].busy;
      done_vec[k] = stat[k].done;
    end
  end

  // Lowest free slot takes the new window; lowest completing slot reports
  assign alloc_vec = free_vec & (~free_vec + HASH_SLOTS'(1));
  assign sel_vec   = done_vec & (~done_vec + HASH_SLOTS'(1));

  for (genvar g = 0; g < HASH_SLOTS; g++) begin : g_slot
    slot_ctl_t ctl;
    assign ctl.absorb = in_acc;
    assign ctl.start  = in_acc & sample_hit & alloc_vec[g];
    assign ctl.last   = in_tlast;

    swf_slot #(
      .WINDOW_BYTES  (WINDOW_BYTES),
      .POSITION_BITS (POSITION_BITS)
    ) u_slot (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .data_byte  (in_tdata),
      .position   (position_r),
      .stat       (stat[g]),
      .round_hash (r_hash[g]),
      .start_pos  (s_pos[g])
    );
  end

  // Pick the completing window's round hash and start position
  logic [HASH_W-1:0]        sel_hash;
  logic [POSITION_BITS-1:0] sel_pos;

  always_comb begin
    sel_hash = '0;
    sel_pos  = '0;
    for (int k = 0; k < HASH_SLOTS; k++) begin
      sel_hash = sel_hash | (r_hash[k] & {HASH_W{sel_vec[k]}});
      sel_pos  = sel_pos  | (s_pos[k]  & {POSITION_BITS{sel_vec[k]}});
    end
  end

  // --------------------------------------------------------------------------
  // Result path: hold the raw hash, then finish it into the output register
  // --------------------------------------------------------------------------
  logic [HASH_W-1:0]   s1_hash_r;
  logic [MARKER_W-1:0] s1_marker_r;
  logic                out_v_r;
  logic [OUT_W-1:0]    out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_acc & (|done_vec) & ~in_tlast;
      end
      if (out_ready) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_hash_r   <= sel_hash;
      s1_marker_r <= MARKER_W'(sel_pos);
    end
    if (out_ready) begin
      out_data_r <= {hash_finish(s1_hash_r), s1_marker_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule
